FILE: hw/rtl/fls_pkg.sv
// Shared types and codes for the free-list slot allocator.
// No dependencies; fls_engine and the top level refer to it by scoped names.
package fls_pkg;

    localparam int IDX_W      = 10;    // slot index field width
    localparam int COUNT_W    = 11;    // item_count register width
    localparam int RST_COUNT  = 1024;  // item_count after reset

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REBUILD = 2'd2;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_EMPTY   = 2'd1;
    localparam logic [1:0] STS_NO_SLOT = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [IDX_W-1:0] item_index;
        logic             no_item;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] slot_index;
        logic             slot_valid;
    } t_rsp;

    // One link store entry: successor present flag and successor slot.
    typedef struct packed {
        logic             v;
        logic [IDX_W-1:0] idx;
    } t_link;

    localparam int LINK_W = $bits(t_link);

    typedef enum logic {
        ST_IDLE,
        ST_BUILD
    } t_state;

endpackage

FILE: hw/rtl/fls_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
module fls_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/fls_engine.sv
// Free-list engine: head register, prefetched head link, rebuild sequencer.
// Depends on fls_pkg; drives the link RAM ports of the top level.
module fls_engine #(
    parameter int SLOTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fls_pkg::COUNT_W-1:0]   i_cfg_data,
    input  logic                          i_accept,
    input  fls_pkg::t_req                 i_req,
    output fls_pkg::t_rsp                 o_rsp,
    output logic                          o_busy,
    output logic                          o_ram_we,
    output logic [$clog2(SLOTS)-1:0]      o_ram_waddr,
    output fls_pkg::t_link                o_ram_wdata,
    output logic                          o_ram_re,
    output logic [$clog2(SLOTS)-1:0]      o_ram_raddr,
    input  fls_pkg::t_link                i_ram_rdata
);

    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = IW + 1;
    localparam int XW    = (CW > fls_pkg::COUNT_W) ? CW : fls_pkg::COUNT_W;
    localparam int CMPW  = (CW > fls_pkg::IDX_W) ? CW : fls_pkg::IDX_W;
    localparam int RST_N = (SLOTS > fls_pkg::RST_COUNT) ? fls_pkg::RST_COUNT : SLOTS;

    fls_pkg::t_state               r_state, n_state;
    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 r_limit;
    logic [IW-1:0]                 r_head;
    logic                          r_head_valid;
    fls_pkg::t_link                r_next;
    logic                          r_pend;
    logic [fls_pkg::COUNT_W-1:0]   r_item_count;

    logic           build_step;
    logic           is_alloc, is_free, is_rebuild;
    logic           item_in_pool, alloc_ok, free_ok, rebuild_go;
    fls_pkg::t_link eff_next, push_link;
    logic [CW-1:0]  limit_new;

    assign is_alloc   = (i_req.command == fls_pkg::CMD_ALLOC);
    assign is_free    = (i_req.command == fls_pkg::CMD_FREE);
    assign is_rebuild = (i_req.command == fls_pkg::CMD_REBUILD);

    assign item_in_pool = (CMPW'(i_req.item_index) < CMPW'(SLOTS));
    assign alloc_ok     = i_accept && is_alloc && r_head_valid;
    assign free_ok      = i_accept && is_free && !i_req.no_item && item_in_pool;
    assign rebuild_go   = i_accept && is_rebuild;

    // A pending read lands this cycle: take the link straight from the RAM.
    assign eff_next = r_pend ? i_ram_rdata : r_next;

    always_comb begin
        push_link = '0;
        if (r_head_valid) begin
            push_link.v   = 1'b1;
            push_link.idx = fls_pkg::IDX_W'(r_head);
        end
    end

    assign limit_new = (XW'(r_item_count) > XW'(SLOTS)) ? CW'(SLOTS) : CW'(r_item_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fls_pkg::ST_IDLE: begin
                if (rebuild_go && (limit_new != '0)) begin
                    n_state = fls_pkg::ST_BUILD;
                end
            end
            fls_pkg::ST_BUILD: begin
                if ((r_cnt + 1'b1) == r_limit) begin
                    n_state = fls_pkg::ST_IDLE;
                end
            end
            default: n_state = fls_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        build_step = 1'b0;
        o_busy     = 1'b0;
        case (r_state)
            fls_pkg::ST_IDLE: begin
                build_step = 1'b0;
                o_busy     = 1'b0;
            end
            fls_pkg::ST_BUILD: begin
                build_step = 1'b1;
                o_busy     = 1'b1;
            end
            default: begin
                build_step = 1'b0;
                o_busy     = 1'b0;
            end
        endcase
    end

    // Link RAM access: pushes write, allocations prefetch the new head's link.
    assign o_ram_we    = build_step || free_ok;
    assign o_ram_waddr = build_step ? r_cnt[IW-1:0] : IW'(i_req.item_index);
    assign o_ram_wdata = push_link;
    assign o_ram_re    = alloc_ok && eff_next.v;
    assign o_ram_raddr = IW'(eff_next.idx);

    always_comb begin
        o_rsp = '0;
        case (i_req.command)
            fls_pkg::CMD_ALLOC: begin
                if (r_head_valid) begin
                    o_rsp.slot_index = fls_pkg::IDX_W'(r_head);
                    o_rsp.slot_valid = 1'b1;
                end else begin
                    o_rsp.status = fls_pkg::STS_EMPTY;
                end
            end
            fls_pkg::CMD_FREE: begin
                if (i_req.no_item || !item_in_pool) begin
                    o_rsp.status = fls_pkg::STS_NO_SLOT;
                end
            end
            default: o_rsp = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fls_pkg::ST_BUILD;
            r_cnt        <= '0;
            r_limit      <= CW'(RST_N);
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_next       <= '0;
            r_pend       <= 1'b0;
            r_item_count <= fls_pkg::COUNT_W'(fls_pkg::RST_COUNT);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_item_count <= i_cfg_data;
            end
            if (build_step) begin
                r_head       <= r_cnt[IW-1:0];
                r_head_valid <= 1'b1;
                r_next       <= push_link;
                r_cnt        <= r_cnt + 1'b1;
            end else if (rebuild_go) begin
                r_head       <= '0;
                r_head_valid <= 1'b0;
                r_next       <= '0;
                r_pend       <= 1'b0;
                r_cnt        <= '0;
                r_limit      <= limit_new;
            end else if (alloc_ok) begin
                r_head       <= eff_next.v ? IW'(eff_next.idx) : '0;
                r_head_valid <= eff_next.v;
                r_pend       <= eff_next.v;
            end else if (free_ok) begin
                r_head       <= IW'(i_req.item_index);
                r_head_valid <= 1'b1;
                r_next       <= push_link;
                r_pend       <= 1'b0;
            end else if (r_pend) begin
                r_next <= i_ram_rdata;
                r_pend <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/free_list_slot_allocator.sv
// Free-list slot allocator: LIFO pool of slot indices with a RAM link store.
// A result beat is registered at its accepting edge and offered the next cycle.
// Allocate and free are accepted back to back while the result register drains; the head's
// successor link is prefetched from the registered-read link RAM and forwarded.
// Rebuild walks min(item_count, SLOTS) slots in the sequencer, input held off.
// Reset runs a rebuild of min(1024, SLOTS) slots; depends on fls_pkg, fls_engine, fls_ram.
module free_list_slot_allocator #(
    parameter int SLOTS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  fls_pkg::t_req               i_req,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output fls_pkg::t_rsp               o_rsp,
    // item_count register
    input  logic                        i_cfg_we,
    input  logic [fls_pkg::COUNT_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(SLOTS);

    logic               accept;
    logic               busy;
    fls_pkg::t_rsp      eng_rsp;
    logic               ram_we, ram_re;
    logic [IW-1:0]      ram_waddr, ram_raddr;
    fls_pkg::t_link     ram_wdata, ram_rdata;

    logic               r_out_valid;
    fls_pkg::t_rsp      r_out;

    // Take a request beat whenever the sequencer is free and the result
    // register is empty or draining this cycle.
    assign o_ready = !busy && (!r_out_valid || i_ready);
    assign accept  = i_valid && o_ready;

    fls_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_req       (i_req),
        .o_rsp       (eng_rsp),
        .o_busy      (busy),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Successor link of every free slot; each entry is written before it is read.
    fls_ram #(
        .WIDTH (fls_pkg::LINK_W),
        .DEPTH (SLOTS)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result register: load on accept, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= eng_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule
